### rtl/nmtbl_pkg.sv
// ----------------------------------------------------------------------------
// nmtbl_pkg
// Shared types, codes and constants for the name table.
// ----------------------------------------------------------------------------
package nmtbl_pkg;

    localparam int TABLE_SLOTS = 1024;           // power of two
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int NAME_BYTES  = 16;
    localparam int LEN_W       = $clog2(NAME_BYTES);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_LONG = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_DUP  = 3'd3;
    localparam logic [2:0] ST_MISS = 3'd4;

    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_N  = 32'he6546b64;
    localparam logic [31:0] MM_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

    typedef logic [3:0] op_t;
    localparam op_t OP_IDLE = 4'd0;
    localparam op_t OP_LOAD = 4'd1;
    localparam op_t OP_K1   = 4'd2;
    localparam op_t OP_K2   = 4'd3;
    localparam op_t OP_HUPD = 4'd4;
    localparam op_t OP_F1   = 4'd5;
    localparam op_t OP_F2   = 4'd6;
    localparam op_t OP_F3   = 4'd7;
    localparam op_t OP_READ = 4'd8;
    localparam op_t OP_NEXT = 4'd9;
    localparam op_t OP_INS  = 4'd10;
    localparam op_t OP_CLRW = 4'd11;
    localparam op_t OP_RSP  = 4'd12;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key_low;
        logic [55:0] key_high;
        logic [4:0]  key_len;
        logic [31:0] new_value;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      found_value;
        logic [CNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] key_lo;
        logic [59:0] key_hl;     // length in 59:56, bytes 8..14 below
        logic [31:0] value;
    } slot_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] rsp_status;
        logic       rsp_found;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       too_long;
        logic       full;
        logic       nb_zero;
        logic       blk_last;
        logic       hit;
        logic       empty;
        logic       pass_last;
        logic       sweep_last;
    } dp_stat_t;

endpackage

### rtl/murmur3_linear_probe_name_table.sv
// ----------------------------------------------------------------------------
// murmur3_linear_probe_name_table
// Name table: open addressing, linear probing, MurmurHash3 x86_32 home slot.
// ----------------------------------------------------------------------------
//  channel | signals                 | transaction
//  --------+-------------------------+------------------------------------
//  req     | req_valid, req_ready    | insert / lookup / clear request
//  rsp     | rsp_valid, rsp_ready    | status, found value, entry count
//
// Hash loads the request, then runs K1, K2 and an update step per 4-byte
// block (up to 4 blocks) and three finalize steps, all through one shared
// 32x32 multiplier; each probe then reads and checks the single-port slot
// memory before the result is handed off. A clear request sweeps all slots,
// one per cycle; the same sweep runs after reset before req_ready rises.
// A finished result waits in the output register; a new request is taken
// meanwhile and only the next handoff waits on rsp_ready.
// ----------------------------------------------------------------------------
module murmur3_linear_probe_name_table
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  nmtbl_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output nmtbl_pkg::rsp_t rsp
);
    import nmtbl_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    nmtbl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    nmtbl_dp u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

### rtl/nmtbl_dp.sv
// ----------------------------------------------------------------------------
// nmtbl_dp
// Datapath: request registers, hash unit with one shared multiplier,
// probe pointer, slot memory, fill count and response register.
// ----------------------------------------------------------------------------
module nmtbl_dp
(
    input  logic              clk,
    input  logic              rst_n,
    input  nmtbl_pkg::req_t   req,
    input  nmtbl_pkg::cmd_t   cmd,
    output nmtbl_pkg::dp_stat_t stat,
    output nmtbl_pkg::rsp_t   rsp
);
    import nmtbl_pkg::*;

    logic [63:0]      key_lo_reg, key_lo_next;
    logic [55:0]      key_hi_reg, key_hi_next;
    logic [LEN_W-1:0] len_reg;
    logic [31:0]      val_reg;
    logic [31:0]      h_reg, h_next;
    logic [31:0]      hk_reg, hk_next;
    logic [1:0]       blk_reg, blk_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] count_reg, count_next;
    slot_t            rdata_reg;
    rsp_t             rsp_reg;
    slot_t            mem [TABLE_SLOTS];

    logic [127:0] name_w;
    logic [31:0]  k_word;
    logic [31:0]  mul_a, mul_b, mul_p;
    logic [31:0]  t_upd, t_rot, t_f1, t_f2, t_f3;
    logic [LEN_W:0] nb_sum;
    logic [2:0]   nb;
    logic         blk_full;
    logic         mem_we;
    slot_t        mem_wdata;

    // name masking: bytes at or past key_len read as zero
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            key_lo_next[8*i +: 8] = (5'(i) < req.key_len) ? req.key_low[8*i +: 8] : 8'h00;
        end
        for (int i = 0; i < 7; i++)
        begin
            key_hi_next[8*i +: 8] = (5'(i + 8) < req.key_len) ?
                                    req.key_high[8*i +: 8] : 8'h00;
        end
    end

    assign name_w   = {8'h00, key_hi_reg, key_lo_reg};
    assign k_word   = name_w[{blk_reg, 5'b0} +: 32];
    assign nb_sum   = {1'b0, len_reg} + (LEN_W+1)'(3);
    assign nb       = 3'(nb_sum >> 2);
    assign blk_full = blk_reg < len_reg[LEN_W-1:2];

    assign t_upd = h_reg ^ hk_reg;
    assign t_rot = {t_upd[18:0], t_upd[31:19]};
    assign t_f1  = (h_reg ^ 32'(len_reg)) ^ ((h_reg ^ 32'(len_reg)) >> 16);
    assign t_f2  = h_reg ^ (h_reg >> 13);
    assign t_f3  = h_reg ^ (h_reg >> 16);

    // shared multiplier
    always_comb
    begin
        unique case (cmd.op)
            OP_K1:   begin mul_a = k_word;                      mul_b = MM_C1; end
            OP_K2:   begin mul_a = {hk_reg[16:0], hk_reg[31:17]}; mul_b = MM_C2; end
            OP_F1:   begin mul_a = t_f1;                        mul_b = MM_F1; end
            OP_F2:   begin mul_a = t_f2;                        mul_b = MM_F2; end
            default: begin mul_a = 32'h0;                       mul_b = 32'h0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        h_next     = h_reg;
        hk_next    = hk_reg;
        blk_next   = blk_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_wdata  = '0;
        unique case (cmd.op)
            OP_LOAD:
            begin
                h_next   = 32'h0;
                blk_next = 2'd0;
                idx_next = '0;
                if (req.req_type == REQ_CLEAR)
                begin
                    count_next = '0;
                end
            end
            OP_K1, OP_K2: hk_next = mul_p;
            OP_HUPD:
            begin
                h_next   = blk_full ? ((t_rot << 2) + t_rot + MM_N) : t_upd;
                blk_next = blk_reg + 2'd1;
            end
            OP_F1, OP_F2: h_next = mul_p;
            OP_F3:
            begin
                idx_next = t_f3[IDX_W-1:0];
                n_next   = '0;
            end
            OP_NEXT:
            begin
                idx_next = idx_reg + IDX_W'(1);
                n_next   = n_reg + IDX_W'(1);
            end
            OP_INS:
            begin
                mem_we     = 1'b1;
                mem_wdata  = '{valid: 1'b1, key_lo: key_lo_reg,
                               key_hl: {len_reg, key_hi_reg}, value: val_reg};
                count_next = count_reg + CNT_W'(1);
            end
            OP_CLRW:
            begin
                mem_we   = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg   <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            blk_reg   <= blk_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg  <= h_next;
        hk_reg <= hk_next;
        if (cmd.op == OP_LOAD)
        begin
            key_lo_reg <= key_lo_next;
            key_hi_reg <= key_hi_next;
            len_reg    <= req.key_len[LEN_W-1:0];
            val_reg    <= req.new_value;
        end
        if (cmd.op == OP_RSP)
        begin
            rsp_reg.status      <= cmd.rsp_status;
            rsp_reg.found_value <= cmd.rsp_found ? rdata_reg.value : 32'h0;
            rsp_reg.entry_count <= count_reg;
        end
    end

    // slot memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        if (cmd.op == OP_READ)
        begin
            rdata_reg <= mem[idx_reg];
        end
    end

    assign stat.req_type   = req.req_type;
    assign stat.too_long   = req.key_len > 5'(NAME_BYTES - 1);
    assign stat.full       = count_reg >= CNT_W'(TABLE_SLOTS);
    assign stat.nb_zero    = len_reg == '0;
    assign stat.blk_last   = {1'b0, blk_reg} == (nb - 3'd1);
    assign stat.hit        = rdata_reg.valid && rdata_reg.key_lo == key_lo_reg
                             && rdata_reg.key_hl == {len_reg, key_hi_reg};
    assign stat.empty      = !rdata_reg.valid;
    assign stat.pass_last  = &n_reg;
    assign stat.sweep_last = &idx_reg;
    assign rsp             = rsp_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_SLOTS))
        else $error("fill count above slot count");
    a_ins_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_INS |-> !rdata_reg.valid)
        else $error("insert into occupied slot");
    a_next_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_NEXT |-> !(&n_reg))
        else $error("probe step past a full pass");
`endif

endmodule

### rtl/nmtbl_ctrl.sv
// ----------------------------------------------------------------------------
// nmtbl_ctrl
// Controller: sequences hash, probe, clear sweep and response handoff.
// ----------------------------------------------------------------------------
module nmtbl_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  nmtbl_pkg::dp_stat_t   stat,
    output nmtbl_pkg::cmd_t       cmd
);
    import nmtbl_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_K1   = 4'd2;
    localparam logic [3:0] S_K2   = 4'd3;
    localparam logic [3:0] S_HU   = 4'd4;
    localparam logic [3:0] S_F1   = 4'd5;
    localparam logic [3:0] S_F2   = 4'd6;
    localparam logic [3:0] S_F3   = 4'd7;
    localparam logic [3:0] S_RD   = 4'd8;
    localparam logic [3:0] S_CHK  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] type_reg, type_next;
    logic [2:0] status_reg, status_next;
    logic       found_reg, found_next;
    logic       pend_reg, pend_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       is_ins;

    assign is_ins    = type_reg == REQ_INSERT;
    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '{op: OP_IDLE, rsp_status: status_reg, rsp_found: found_reg};
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLRW;
                if (stat.sweep_last)
                begin
                    state_next = pend_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op      = OP_LOAD;
                    type_next   = stat.req_type;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    priority if (stat.req_type == REQ_NONE)
                        state_next = S_DONE;
                    else if (stat.req_type == REQ_CLEAR)
                    begin
                        pend_next  = 1'b1;
                        state_next = S_CLR;
                    end
                    else if (stat.too_long)
                    begin
                        status_next = ST_LONG;
                        state_next  = S_DONE;
                    end
                    else if (stat.req_type == REQ_INSERT && stat.full)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_K1;
                end
            end
            S_K1:
            begin
                if (stat.nb_zero)
                begin
                    cmd.op     = OP_F1;
                    state_next = S_F2;
                end
                else
                begin
                    cmd.op     = OP_K1;
                    state_next = S_K2;
                end
            end
            S_K2:
            begin
                cmd.op     = OP_K2;
                state_next = S_HU;
            end
            S_HU:
            begin
                cmd.op     = OP_HUPD;
                state_next = stat.blk_last ? S_F1 : S_K1;
            end
            S_F1:
            begin
                cmd.op     = OP_F1;
                state_next = S_F2;
            end
            S_F2:
            begin
                cmd.op     = OP_F2;
                state_next = S_F3;
            end
            S_F3:
            begin
                cmd.op     = OP_F3;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.op     = OP_READ;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                priority if (stat.hit)
                begin
                    status_next = is_ins ? ST_DUP : ST_OK;
                    found_next  = !is_ins;
                    state_next  = S_DONE;
                end
                else if (stat.empty)
                begin
                    if (is_ins)
                        cmd.op = OP_INS;
                    status_next = is_ins ? ST_OK : ST_MISS;
                    state_next  = S_DONE;
                end
                else if (stat.pass_last)
                begin
                    status_next = is_ins ? ST_FULL : ST_MISS;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.op         = OP_RSP;
                    rsp_valid_next = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            type_reg      <= REQ_NONE;
            status_reg    <= ST_OK;
            found_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            type_reg      <= type_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside done state");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp_valid_reg && !rsp_ready) |=> state_reg == S_DONE)
        else $error("result dropped while output stalled");
    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= S_DONE)
        else $error("illegal controller state");
`endif

endmodule
